FILE: hdl/slsp_pkg.sv
package slsp_pkg;

  // position format
  localparam int POS_W         = 24;
  localparam int FRAC_OUT_W    = 16;
  localparam int FRACTION_BITS = 16;

  // table
  localparam int NUM_ENTRIES = 4;
  localparam int TABLE_DEPTH = 4;
  localparam int IDX_W       = 2;
  localparam int COUNT_W     = 3;

  // slew and dwell
  localparam int STEP_W  = 16;
  localparam int LIMIT_W = 16;
  localparam int DWELL_W = 17;
  localparam int ERR_W   = POS_W + 2;

  // command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ENTRY_0     = 3'd0;
  localparam logic [2:0] CFG_ENTRY_1     = 3'd1;
  localparam logic [2:0] CFG_ENTRY_2     = 3'd2;
  localparam logic [2:0] CFG_ENTRY_3     = 3'd3;
  localparam logic [2:0] CFG_SLEW_STEP   = 3'd4;
  localparam logic [2:0] CFG_DWELL_LIMIT = 3'd5;
  localparam logic [2:0] CFG_ENTRY_COUNT = 3'd6;

  localparam logic [POS_W-1:0] ENTRY_RESET [NUM_ENTRIES] = '{
    24'sd98304, -24'sd98304, 24'sd163840, -24'sd163840
  };
  localparam logic [STEP_W-1:0]  SLEW_RESET  = 16'd66;
  localparam logic [LIMIT_W-1:0] DWELL_RESET = 16'd1000;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [POS_W-1:0] start_position;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] target_position;
    logic [FRAC_OUT_W-1:0]   wrapped_setpoint;
    logic [IDX_W-1:0]        entry_index;
    logic                    at_entry;
  } out_item_t;

endpackage

FILE: hdl/slew_limited_setpoint_sequencer_core.sv
// Slew-limited setpoint sequencer. Each transfer on the input channel carries one
// command: tick moves the held target toward the current table entry by at most
// slew_step (snapping onto the entry once within a step) and runs the dwell
// counter while on the entry; after more than dwell_limit ticks on the entry the
// index advances and wraps at entry_count (0 acts as 1, above 4 acts as 4).
// Load copies start_position into the target, restart clears index and dwell
// count, and code 3 changes nothing. Every command yields exactly one result with
// the new target, its fraction, the index and an at-entry flag. Timing: an item
// is held in the input register, is evaluated in one pass of an add, compare
// and counter update, and lands in the result register; a new item is taken
// every cycle while the result side keeps up.
// Configuration writes are always ready and must only be made with the block idle.
module slew_limited_setpoint_sequencer_core
  import slsp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  // command channel
  input  logic           in_valid,
  output logic           in_stall,
  input  in_item_t       in_data,
  // result channel
  output logic           out_valid,
  input  logic           out_stall,
  output out_item_t      out_data,
  // configuration write channel
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [POS_W-1:0] cfg_data
);

  // configuration registers
  logic [POS_W-1:0]   entry [NUM_ENTRIES];
  logic [STEP_W-1:0]  slew_step;
  logic [LIMIT_W-1:0] dwell_limit;
  logic [COUNT_W-1:0] entry_count;

  // sequencer state
  logic signed [POS_W-1:0] current_target;
  logic [IDX_W-1:0]        table_index;
  logic [DWELL_W-1:0]      dwell_count;

  // input register and result register
  logic      in_full;
  in_item_t  in_hold;
  logic      out_full;
  out_item_t out_hold;

  logic advance;
  logic in_take;

  // next state from the held item
  logic signed [POS_W-1:0] target_next;
  logic [IDX_W-1:0]        table_index_next;
  logic [DWELL_W-1:0]      dwell_count_next;
  out_item_t               result_next;

  // tick datapath
  logic signed [ERR_W-1:0] goal_ext;
  logic signed [ERR_W-1:0] now_ext;
  logic signed [ERR_W-1:0] step_ext;
  logic signed [ERR_W-1:0] err;
  logic                    above;
  logic                    below;
  logic signed [ERR_W-1:0] tick_sum;
  logic [DWELL_W-1:0]      dwell_inc;
  logic [COUNT_W-1:0]      eff_count;
  logic [COUNT_W-1:0]      idx_inc;
  logic [POS_W+FRAC_OUT_W-1:0] frac_ext;

  // pipeline handshake: the held item moves on when the result slot is free or
  // its result is being taken in this cycle
  assign advance   = in_full && (!out_full || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_full;
  assign out_data  = out_hold;
  assign cfg_ready = 1'b1;

  // clamp entry count to 1..TABLE_DEPTH
  always_comb begin
    eff_count = entry_count;
    if (eff_count == '0) begin
      eff_count = COUNT_W'(1);
    end
    if (eff_count > COUNT_W'(TABLE_DEPTH)) begin
      eff_count = COUNT_W'(TABLE_DEPTH);
    end
  end

  // slew-limited step toward the current entry
  always_comb begin
    goal_ext = ERR_W'($signed(entry[table_index]));
    now_ext  = ERR_W'(current_target);
    step_ext = $signed({{(ERR_W-STEP_W){1'b0}}, slew_step});
    err      = goal_ext - now_ext;
    above    = err > step_ext;
    below    = err < -step_ext;
    if (above) begin
      tick_sum = now_ext + step_ext;
    end else if (below) begin
      tick_sum = now_ext - step_ext;
    end else begin
      tick_sum = goal_ext;
    end
    dwell_inc = dwell_count + DWELL_W'(1);
    idx_inc   = {1'b0, table_index} + COUNT_W'(1);
  end

  // command decode
  always_comb begin
    target_next      = current_target;
    table_index_next = table_index;
    dwell_count_next = dwell_count;
    case (in_hold.command)
      CMD_TICK: begin
        target_next = tick_sum[POS_W-1:0];
        // on the entry: count dwell, advance when past the limit
        if (!above && !below) begin
          dwell_count_next = dwell_inc;
          if (dwell_inc > DWELL_W'(dwell_limit)) begin
            dwell_count_next = '0;
            if (idx_inc >= eff_count) begin
              table_index_next = '0;
            end else begin
              table_index_next = idx_inc[IDX_W-1:0];
            end
          end
        end
      end
      CMD_LOAD: begin
        target_next = in_hold.start_position;
      end
      CMD_RESTART: begin
        table_index_next = '0;
        dwell_count_next = '0;
      end
      default: begin
        // unused code: state holds
      end
    endcase
  end

  // result fields from the new state
  always_comb begin
    frac_ext = {target_next, {FRAC_OUT_W{1'b0}}};
    result_next.target_position  = target_next;
    result_next.wrapped_setpoint = frac_ext[FRACTION_BITS+FRAC_OUT_W-1 -: FRAC_OUT_W];
    result_next.entry_index      = table_index_next;
    result_next.at_entry         = (target_next == $signed(entry[table_index_next]));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entry[i] <= ENTRY_RESET[i];
      end
      slew_step   <= SLEW_RESET;
      dwell_limit <= DWELL_RESET;
      entry_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENTRY_0, CFG_ENTRY_1, CFG_ENTRY_2, CFG_ENTRY_3: begin
          entry[cfg_index[IDX_W-1:0]] <= cfg_data;
        end
        CFG_SLEW_STEP:   slew_step   <= cfg_data[STEP_W-1:0];
        CFG_DWELL_LIMIT: dwell_limit <= cfg_data[LIMIT_W-1:0];
        CFG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_W-1:0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // state and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      current_target <= '0;
      table_index    <= '0;
      dwell_count    <= '0;
      in_full        <= 1'b0;
      out_full       <= 1'b0;
    end else begin
      if (advance) begin
        current_target <= target_next;
        table_index    <= table_index_next;
        dwell_count    <= dwell_count_next;
      end
      in_full  <= in_take || (in_full && !advance);
      out_full <= advance || (out_full && out_stall);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_hold <= in_data;
    end
    if (advance) begin
      out_hold <= result_next;
    end
  end

  // a stall is only raised while an item is held
  assert property (@(posedge clk) disable iff (rst) !in_full |-> !in_stall)
    else $error("input stall raised with empty input register");

  // an evaluated item always lands in the result register
  assert property (@(posedge clk) disable iff (rst) advance |=> out_full)
    else $error("evaluated item lost");

  // a fresh result mirrors the new sequencer state that it was computed with
  assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_hold.target_position == current_target) &&
                (out_hold.entry_index == table_index))
    else $error("result and sequencer state disagree");

endmodule
